@@ design/srgb2lab_pkg.sv @@
// srgb2lab_pkg: constants, types and table builders for the sRGB to CIE L*a*b* pipeline.
// Standalone package; used by srgb_to_cielab_pixel_top.
package srgb2lab_pkg;

  // Row-wise sRGB to XYZ matrix, each coefficient divided by its white component, Q30.
  localparam logic [29:0] MAT_Q30 [9] = '{
    30'(((64'd4124564 << 30) + 64'd9504560 / 2) / 64'd9504560),
    30'(((64'd3575761 << 30) + 64'd9504560 / 2) / 64'd9504560),
    30'(((64'd1804375 << 30) + 64'd9504560 / 2) / 64'd9504560),
    30'(((64'd2126729 << 30) + 64'd10000000 / 2) / 64'd10000000),
    30'(((64'd7151522 << 30) + 64'd10000000 / 2) / 64'd10000000),
    30'(((64'd721750 << 30) + 64'd10000000 / 2) / 64'd10000000),
    30'(((64'd193339 << 30) + 64'd10887540 / 2) / 64'd10887540),
    30'(((64'd1191920 << 30) + 64'd10887540 / 2) / 64'd10887540),
    30'(((64'd9503041 << 30) + 64'd10887540 / 2) / 64'd10887540)
  };

  // t (Q42) above this takes the cube root branch.
  localparam logic [35:0] T_THRESH = 36'((64'd8856 << 42) / 64'd1000000);

  // Linear segment: floor((9033 t + 160*2^42 + 580*2^21) / (1160*2^21)).
  localparam logic [50:0] LIN_OFS   = (51'd160 << 42) + (51'd580 << 21);
  localparam logic [13:0] LIN_SLOPE = 14'd9033;
  localparam int          RECIP_SH  = 42;
  localparam logic [31:0] RECIP_1160 = 32'(((64'd1 << 42) + 64'd1159) / 64'd1160);

  localparam int CBRT_STEPS = 22;

  typedef struct packed {
    logic [21:0] root;
    logic [43:0] sq;
    logic [45:0] rem;
    logic [65:0] rad;
  } cbrt_t;

  function automatic logic [63:0] mul62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] pr;
    pr = 128'(a) * 128'(b);
    return 64'(pr >> 62);
  endfunction

  function automatic logic [63:0] pow5_62(input logic [63:0] y);
    logic [63:0] y2;
    y2 = mul62(y, y);
    return mul62(mul62(y2, y2), y);
  endfunction

  // Linear-light value of one sRGB code, Q30, exact integer evaluation.
  function automatic logic [30:0] gamma_entry(input int unsigned code);
    logic [127:0] p;
    logic [63:0]  lin;
    logic [63:0]  t62;
    logic [63:0]  t2;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    if (code <= 10) begin
      lin = ((64'(code) * 64'd100) << 31) / 64'd329460;
      return 31'((lin + 64'd1) >> 1);
    end
    p   = 128'(code) * 128'd1000 + 128'd14025;
    t62 = 64'((p << 62) / 128'd269025);
    t2  = mul62(t62, t62);
    lo  = '0;
    hi  = 64'd1 << 62;
    for (int i = 0; i < 63; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_62(mid) <= t2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return 31'((mul62(t2, lo) + (64'd1 << 31)) >> 32);
  endfunction

endpackage

@@ design/srgb_to_cielab_pixel_top.sv @@
// srgb_to_cielab_pixel_top: pipelined sRGB (D65) to CIE L*a*b* converter.
// Depends on srgb2lab_pkg (matrix, thresholds, gamma table builder, cube root state).
//
// One pixel beat is taken on every clock where start is high; busy is low at all
// times outside reset, since the receiver cannot stall and nothing inside waits.
// Each beat comes back in order on lightness/green_red/blue_yellow with done high
// for one cycle. The latency is set by the cube root, which resolves one result bit
// per stage over 22 stages, after gamma lookup, matrix products and the row sums;
// two more stages scale, round and saturate.
// Outputs carry OUT_FRAC_BITS fraction bits; a beat with in_mask low returns zeros.
module srgb_to_cielab_pixel_top
  import srgb2lab_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         blue,
  input  logic [7:0]         green,
  input  logic [7:0]         red,
  input  logic               in_mask,
  output logic               done,
  output logic [14:0]        lightness,
  output logic signed [15:0] green_red,
  output logic signed [15:0] blue_yellow
);

  localparam int SHIFT   = 21 - OUT_FRAC_BITS;
  localparam int LATENCY = CBRT_STEPS + 5;

  logic [30:0] gamma_rom [256];

  for (genvar g = 0; g < 256; g++) begin : g_gamma
    localparam logic [30:0] Entry = gamma_entry(g);
    assign gamma_rom[g] = Entry;
  end

  function automatic cbrt_t cbrt_step(input cbrt_t cur);
    cbrt_t       nxt;
    logic [48:0] rem_b;
    logic [48:0] cost;
    rem_b = {cur.rem, cur.rad[65:63]};
    cost  = (49'(cur.sq) << 3) + (49'(cur.sq) << 2) + (49'(cur.root) << 2)
          + (49'(cur.root) << 1) + 49'd1;
    nxt.rad = cur.rad << 3;
    if (rem_b >= cost) begin
      nxt.root = {cur.root[20:0], 1'b1};
      nxt.sq   = (cur.sq << 2) + (44'(cur.root) << 2) + 44'd1;
      nxt.rem  = 46'(rem_b - cost);
    end else begin
      nxt.root = {cur.root[20:0], 1'b0};
      nxt.sq   = cur.sq << 2;
      nxt.rem  = 46'(rem_b);
    end
    return nxt;
  endfunction

  function automatic logic signed [32:0] round_sh(input logic signed [32:0] v);
    logic signed [32:0] half;
    half = 33'sd1 <<< (SHIFT - 1);
    if (v[32]) begin
      return (v + half - 33'sd1) >>> SHIFT;
    end
    return (v + half) >>> SHIFT;
  endfunction

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // valid / mask chain
  logic v1, v2, v3, v26;
  logic m1, m2, m3, m26;
  logic vc [CBRT_STEPS];
  logic mc [CBRT_STEPS];

  // payload
  logic [30:0]        lin1 [3];
  logic [59:0]        prod2 [9];
  logic [42:0]        t3 [3];
  cbrt_t              cb [3][CBRT_STEPS];
  logic               lf [3][CBRT_STEPS];
  logic [29:0]        lu [3];
  logic [61:0]        lp [3];
  logic [19:0]        lq [3][CBRT_STEPS - 2];
  logic signed [32:0] lraw, araw, braw;

  logic [21:0]        fsel [3];
  logic signed [32:0] lrnd, arnd, brnd;
  logic [14:0]        lightness_next;
  logic [15:0]        green_red_next, blue_yellow_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v26  <= 1'b0;
      done <= 1'b0;
      for (int k = 0; k < CBRT_STEPS; k++) begin
        vc[k] <= 1'b0;
      end
    end else begin
      v1    <= accept;
      v2    <= v1;
      v3    <= v2;
      vc[0] <= v3;
      for (int k = 1; k < CBRT_STEPS; k++) begin
        vc[k] <= vc[k - 1];
      end
      v26  <= vc[CBRT_STEPS - 1];
      done <= v26;
    end
  end

  always_ff @(posedge clk) begin
    m1    <= in_mask;
    m2    <= m1;
    m3    <= m2;
    mc[0] <= m3;
    for (int k = 1; k < CBRT_STEPS; k++) begin
      mc[k] <= mc[k - 1];
    end
    m26 <= mc[CBRT_STEPS - 1];

    lin1[0] <= gamma_rom[red];
    lin1[1] <= gamma_rom[green];
    lin1[2] <= gamma_rom[blue];

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod2[i * 3 + j] <= 60'(61'(MAT_Q30[i * 3 + j]) * 61'(lin1[j]));
      end
    end

    for (int i = 0; i < 3; i++) begin
      t3[i] <= 43'((62'(prod2[i * 3]) + 62'(prod2[i * 3 + 1]) + 62'(prod2[i * 3 + 2])
                   + (62'd1 << 17)) >> 18);
    end

    for (int c = 0; c < 3; c++) begin
      cb[c][0] <= cbrt_step('{root: '0, sq: '0, rem: '0, rad: {2'b00, t3[c], 21'd0}});
      for (int k = 1; k < CBRT_STEPS; k++) begin
        cb[c][k] <= cbrt_step(cb[c][k - 1]);
      end

      lf[c][0] <= (t3[c] > 43'(T_THRESH));
      for (int k = 1; k < CBRT_STEPS; k++) begin
        lf[c][k] <= lf[c][k - 1];
      end

      lu[c]    <= 30'((51'(LIN_SLOPE) * 51'(t3[c][35:0]) + LIN_OFS) >> 21);
      lp[c]    <= 62'(lu[c]) * 62'(RECIP_1160);
      lq[c][0] <= 20'(lp[c] >> RECIP_SH);
      for (int k = 1; k < CBRT_STEPS - 2; k++) begin
        lq[c][k] <= lq[c][k - 1];
      end
    end

    lraw <= 33'sd116 * $signed(33'(fsel[1])) - (33'sd16 <<< 21);
    araw <= 33'sd500 * ($signed(33'(fsel[0])) - $signed(33'(fsel[1])));
    braw <= 33'sd200 * ($signed(33'(fsel[1])) - $signed(33'(fsel[2])));

    lightness   <= lightness_next;
    green_red   <= $signed(green_red_next);
    blue_yellow <= $signed(blue_yellow_next);
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fsel[c] = lf[c][CBRT_STEPS - 1] ? cb[c][CBRT_STEPS - 1].root
                                      : {2'b00, lq[c][CBRT_STEPS - 3]};
    end
  end

  always_comb begin
    lrnd = round_sh(lraw);
    arnd = round_sh(araw);
    brnd = round_sh(braw);

    if (lrnd < 0) begin
      lightness_next = '0;
    end else if (lrnd > 33'sd32767) begin
      lightness_next = 15'h7fff;
    end else begin
      lightness_next = lrnd[14:0];
    end

    if (arnd < -33'sd32768) begin
      green_red_next = 16'h8000;
    end else if (arnd > 33'sd32767) begin
      green_red_next = 16'h7fff;
    end else begin
      green_red_next = arnd[15:0];
    end

    if (brnd < -33'sd32768) begin
      blue_yellow_next = 16'h8000;
    end else if (brnd > 33'sd32767) begin
      blue_yellow_next = 16'h7fff;
    end else begin
      blue_yellow_next = brnd[15:0];
    end

    if (!m26) begin
      lightness_next   = '0;
      green_red_next   = '0;
      blue_yellow_next = '0;
    end
  end

`ifndef SYNTHESIS
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result beat without matching input beat");

  a_mask_zero: assert property (@(posedge clk) disable iff (rst)
    done && !$past(in_mask, LATENCY) |->
      lightness == 15'd0 && green_red == 16'sd0 && blue_yellow == 16'sd0)
    else $error("masked beat gave nonzero result");

  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    done && $past(in_mask && red == 8'd0 && green == 8'd0 && blue == 8'd0, LATENCY) |->
      lightness == 15'd0 && green_red == 16'sd0 && blue_yellow == 16'sd0)
    else $error("black pixel did not convert to zero");
`endif

endmodule

@@ bench/srgb_to_cielab_pixel_top_test.sv @@
// srgb_to_cielab_pixel_top_test: self-checking bench for the sRGB to CIE L*a*b* pixel converter.
// Predicts every beat with an integer model of gamma decode, XYZ matrix and f();
// needs only srgb_to_cielab_pixel_top and its package.
module srgb_to_cielab_pixel_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS    = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int DRAIN_LIMIT  = 1000;

  typedef struct {
    logic [14:0]        l_star;
    logic signed [15:0] a_star;
    logic signed [15:0] b_star;
  } lab_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [7:0]         blue;
  logic [7:0]         green;
  logic [7:0]         red;
  logic               in_mask;
  logic               done;
  logic [14:0]        lightness;
  logic signed [15:0] green_red;
  logic signed [15:0] blue_yellow;

  logic [63:0] lin_q30 [256];
  logic [63:0] xyz_q30 [9];
  lab_t        pending_lab [$];
  int          err_count;

  srgb_to_cielab_pixel_top #(.OUT_FRAC_BITS(FRAC_BITS)) uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] q62_mul(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[125:62];
  endfunction

  function automatic logic [63:0] q62_pow5(input logic [63:0] y);
    logic [63:0] sq;
    sq = q62_mul(y, y);
    return q62_mul(q62_mul(sq, sq), y);
  endfunction

  function automatic logic [63:0] decode_srgb(input int code);
    logic [127:0] num;
    logic [63:0]  t62;
    logic [63:0]  t2;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    if (code <= 10) begin
      return ((((64'(code) * 64'd100) << 31) / 64'd329460) + 64'd1) >> 1;
    end
    num = 128'(1000 * code + 14025) << 62;
    t62 = 64'(num / 128'd269025);
    t2  = q62_mul(t62, t62);
    lo  = '0;
    hi  = 64'd1 << 62;
    // largest y with y^5 <= t^2, so y = t^0.4 and y * t^2 = t^2.4
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      if (q62_pow5(mid) <= t2) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return (q62_mul(t2, lo) + (64'd1 << 31)) >> 32;
  endfunction

  function automatic logic [63:0] ratio_q30(input longint unsigned n, input longint unsigned d);
    return ((64'(n) << 30) + d / 2) / d;
  endfunction

  task automatic init_tables();
    for (int c = 0; c < 256; c++) begin
      lin_q30[c] = decode_srgb(c);
    end
    xyz_q30[0] = ratio_q30(4124564, 9504560);
    xyz_q30[1] = ratio_q30(3575761, 9504560);
    xyz_q30[2] = ratio_q30(1804375, 9504560);
    xyz_q30[3] = ratio_q30(2126729, 10000000);
    xyz_q30[4] = ratio_q30(7151522, 10000000);
    xyz_q30[5] = ratio_q30(721750, 10000000);
    xyz_q30[6] = ratio_q30(193339, 10887540);
    xyz_q30[7] = ratio_q30(1191920, 10887540);
    xyz_q30[8] = ratio_q30(9503041, 10887540);
  endtask

  // f(t): t in Q42, result in Q21
  function automatic longint curve_q21(input logic [63:0] t42);
    logic [127:0] n;
    logic [127:0] lo;
    logic [127:0] hi;
    logic [127:0] mid;
    if (t42 * 64'd1000000 > (64'd8856 << 42)) begin
      n  = 128'({t42, 21'd0});
      lo = '0;
      hi = (128'd1 << 21) + 128'd4096;
      while (lo < hi) begin
        mid = lo + (hi - lo + 128'd1) / 128'd2;
        if (mid * mid * mid <= n) begin
          lo = mid;
        end else begin
          hi = mid - 128'd1;
        end
      end
      return longint'(lo[63:0]);
    end
    return longint'((64'd9033 * t42 + (64'd160 << 42) + (64'd580 << 21)) / (64'd1160 << 21));
  endfunction

  function automatic longint round_q(input longint v);
    longint half;
    half = longint'(1) << (20 - FRAC_BITS);
    if (v >= 0) begin
      return (v + half) >>> (21 - FRAC_BITS);
    end
    return -((half - v) >>> (21 - FRAC_BITS));
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic lab_t lab_of_pixel(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r, input logic m);
    lab_t        res;
    logic [63:0] rgb [3];
    logic [63:0] acc;
    longint      f [3];
    res.l_star = '0;
    res.a_star = '0;
    res.b_star = '0;
    if (!m) begin
      return res;
    end
    rgb[0] = lin_q30[r];
    rgb[1] = lin_q30[g];
    rgb[2] = lin_q30[b];
    for (int i = 0; i < 3; i++) begin
      acc  = xyz_q30[3*i] * rgb[0] + xyz_q30[3*i+1] * rgb[1] + xyz_q30[3*i+2] * rgb[2];
      f[i] = curve_q21((acc + (64'd1 << 17)) >> 18);
    end
    res.l_star = 15'(sat(round_q(116 * f[1] - (longint'(16) << 21)), 0, 32767));
    res.a_star = 16'(sat(round_q(500 * (f[0] - f[1])), -32768, 32767));
    res.b_star = 16'(sat(round_q(200 * (f[1] - f[2])), -32768, 32767));
    return res;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : check_beats
    lab_t want;
    if (!rst) begin
      if (start && !busy) begin
        pending_lab.push_back(lab_of_pixel(blue, green, red, in_mask));
      end
      if (done === 1'b1) begin
        if (pending_lab.size() == 0) begin
          $error("result beat with no pixel outstanding");
          err_count++;
        end else begin
          want = pending_lab.pop_front();
          compare_field("lightness", int'(want.l_star), int'(lightness));
          compare_field("green_red", int'(want.a_star), int'(green_red));
          compare_field("blue_yellow", int'(want.b_star), int'(blue_yellow));
        end
      end
    end
  end

  task automatic drive_pixel(input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r, input logic m);
    @(negedge clk);
    start   <= 1'b1;
    blue    <= b;
    green   <= g;
    red     <= r;
    in_mask <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
      blue  <= 8'($urandom);
    end
  endtask

  task automatic test_extremes();
    drive_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    drive_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    drive_pixel(8'h00, 8'h00, 8'hff, 1'b1);
    drive_pixel(8'h00, 8'hff, 8'h00, 1'b1);
    drive_pixel(8'hff, 8'h00, 8'h00, 1'b1);
    drive_pixel(8'h00, 8'hff, 8'hff, 1'b1);
    drive_pixel(8'hff, 8'hff, 8'h00, 1'b1);
    drive_pixel(8'hff, 8'h00, 8'hff, 1'b1);
  endtask

  // linear gamma segment edge and the cube root / linear f() split
  task automatic test_gamma_knee();
    drive_pixel(8'd10, 8'd10, 8'd10, 1'b1);
    drive_pixel(8'd11, 8'd11, 8'd11, 1'b1);
    drive_pixel(8'd23, 8'd23, 8'd23, 1'b1);
    drive_pixel(8'd24, 8'd24, 8'd24, 1'b1);
    drive_pixel(8'd1, 8'd0, 8'd0, 1'b1);
    drive_pixel(8'd0, 8'd1, 8'd0, 1'b1);
    drive_pixel(8'd0, 8'd0, 8'd1, 1'b1);
  endtask

  task automatic test_mask();
    drive_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    drive_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    drive_pixel(8'ha5, 8'h5a, 8'hc3, 1'b0);
    drive_pixel(8'ha5, 8'h5a, 8'hc3, 1'b1);
  endtask

  task automatic test_random_stream(input int gap_pct, input int count);
    logic [7:0] ch [3];
    for (int k = 0; k < count; k++) begin
      idle_gap(gap_pct);
      foreach (ch[j]) begin
        ch[j] = ($urandom_range(7) == 0) ? 8'($urandom_range(31)) : 8'($urandom);
      end
      if ($urandom_range(9) == 0) begin
        ch[1] = ch[0];
        ch[2] = ch[0];
      end
      drive_pixel(ch[0], ch[1], ch[2], $urandom_range(7) != 0);
    end
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 12; k++) begin
      drive_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    end
    @(negedge clk);
    start <= 1'b0;
    while (pending_lab.size() != 0) @(posedge clk);
    for (int k = 0; k < 12; k++) begin
      drive_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int waited;
    rst       = 1'b1;
    start     = 1'b0;
    blue      = '0;
    green     = '0;
    red       = '0;
    in_mask   = 1'b0;
    err_count = 0;
    init_tables();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_gamma_knee();
    test_mask();
    test_random_stream(26, 650);
    test_drain_pause();
    test_random_stream(72, 650);
    test_random_stream(0, 700);

    @(negedge clk);
    start  <= 1'b0;
    waited = 0;
    while (pending_lab.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_lab.size() != 0) begin
      $error("%0d pixels never came back", pending_lab.size());
      err_count += pending_lab.size();
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
design/srgb2lab_pkg.sv
design/srgb_to_cielab_pixel_top.sv
bench/srgb_to_cielab_pixel_top_test.sv
